[rtl/tks_pkg.sv]
package tks_pkg;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 12;
	localparam int TOPK_W = 5;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_DRAIN
	} tks_state_t;

	// bits of one kept element as it moves along the chain
	typedef struct packed {
		logic                 vld;
		logic [VALUE_W-1:0]   value;
		logic [INDEX_W-1:0]   index;
	} tks_elem_t;

	// ordered key: monotonic unsigned image of an ieee single
	function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] b);
		order_key = b[VALUE_W-1] ? ~b : (b | {1'b1, {(VALUE_W-1){1'b0}}});
	endfunction
endpackage

[rtl/tks_cell.sv]
module tks_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                ins,
	input  tks_pkg::tks_elem_t  new_elem,
	input  logic                left_take,
	input  tks_pkg::tks_elem_t  left_elem,
	input  logic                shift,
	input  tks_pkg::tks_elem_t  right_elem,
	output logic                take,
	output tks_pkg::tks_elem_t  elem
);
	import tks_pkg::*;

	logic      beats;
	logic      vld_q;
	tks_elem_t data_q;

	// strict greater keeps the lower index ahead on ties
	assign beats = !vld_q || (order_key(new_elem.value) > order_key(data_q.value));
	assign take = ins && beats;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clr) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= right_elem.vld;
		end else if (take) begin
			// an empty left neighbor hands on nothing
			vld_q <= left_take ? left_elem.vld : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= right_elem;
		end else if (take) begin
			data_q <= left_take ? left_elem : new_elem;
		end
	end

	always_comb begin
		elem = data_q;
		elem.vld = vld_q;
	end
endmodule

[rtl/top_k_select.sv]
// Streaming top-k selector over rows of ieee single values. Each word on s_axis
// (tdata = value, tlast = end of row) enters a chain of K_MAX compare/insert
// cells. After tlast the chain shifts its contents out through m_axis, largest
// first, min(top_k, row length) words, tlast on the final pair; input is held
// off during that drain. top_k (cfg) is clamped to 1..K_MAX. Ties keep the
// lower index first.
module top_k_select #(
	parameter int K_MAX = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tks_pkg::TOPK_W-1:0] cfg_wdata,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,  // value_bits
	input  logic                       s_axis_tlast,  // row_end
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [47:0]                m_axis_tdata,  // top_value, top_index, zero pad
	output logic                       m_axis_tlast   // run_last
);
	import tks_pkg::*;

	localparam int CW = $clog2(K_MAX + 1);

	tks_state_t state_q, state_d;
	logic [TOPK_W-1:0] topk_q;
	logic [INDEX_W-1:0] count_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] k_eff;
	logic in_acc, out_acc, shift, clr;
	tks_elem_t new_elem;
	tks_elem_t elems [K_MAX];
	logic takes [K_MAX];

	assign s_axis_tready = (state_q == ST_FILL);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign shift = out_acc;

	assign new_elem = '{vld: 1'b1, value: s_axis_tdata, index: count_q};

	always_comb begin
		if (topk_q == '0) k_eff = CW'(1);
		else if (32'(topk_q) > K_MAX) k_eff = CW'(K_MAX);
		else k_eff = CW'(topk_q);
	end

	genvar g;
	generate
		for (g = 0; g < K_MAX; g++) begin : g_cell
			tks_cell u_cell (
				.clk(clk), .arst_n(arst_n), .clr(clr), .ins(in_acc),
				.new_elem(new_elem),
				.left_take(g == 0 ? 1'b0 : takes[g == 0 ? 0 : g-1]),
				.left_elem(elems[g == 0 ? 0 : g-1]),
				.shift(shift),
				.right_elem(g == K_MAX-1 ? tks_elem_t'('0) : elems[g == K_MAX-1 ? g : g+1]),
				.take(takes[g]), .elem(elems[g])
			);
		end
	endgenerate

	assign m_axis_tvalid = (state_q == ST_DRAIN) && elems[0].vld && (left_q != '0);
	assign m_axis_tdata = {4'b0, elems[0].index, elems[0].value};
	assign m_axis_tlast = (left_q == CW'(1)) || !elems[1 % K_MAX].vld || (K_MAX == 1);

	always_comb begin
		state_d = state_q;
		clr = 1'b0;
		unique case (state_q)
			ST_FILL: if (in_acc && s_axis_tlast) state_d = ST_DRAIN;
			ST_DRAIN: if (out_acc && m_axis_tlast) begin
				state_d = ST_FILL;
				clr = 1'b1;
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			topk_q <= TOPK_W'(1);
			count_q <= '0;
			left_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) topk_q <= cfg_wdata;
			if (in_acc) begin
				if (s_axis_tlast) begin
					count_q <= '0;
					left_q <= k_eff;
				end else if (count_q != {INDEX_W{1'b1}}) begin
					count_q <= count_q + INDEX_W'(1);
				end
			end
			if (out_acc) left_q <= left_q - CW'(1);
		end
	end
endmodule

[rtl/tks_checker.sv]
module tks_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic       m_axis_tlast
);
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input open during drain");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("no return to input after last");
endmodule

bind top_k_select tks_checker u_tks_checker (.*);

[tb/top_k_select_test.sv]
module top_k_select_test;
	import tks_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [4:0]  cfg_wdata = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [47:0] m_axis_tdata;  // top_value, top_index, zero pad
	logic        m_axis_tlast;   // run_last

	typedef struct packed {
		logic [31:0] value;
		logic [11:0] index;
		logic        last;
	} pair_t;

	typedef struct {
		logic [31:0] value;
		logic        row_end;
		logic [4:0]  k;      // top_k written before this word, when cfg set
		logic        cfg;
		logic        chk;    // typed pair below applies
		pair_t       pair;   // expected single pair
	} stim_t;

	localparam int NKEEP = 16;

	// predictor state
	logic [31:0] kv[NKEEP];
	logic [11:0] kp[NKEEP];
	int          kn;
	logic [11:0] pos;
	logic [4:0]  k_reg;

	pair_t pending_pairs[$];
	int    errors = 0;
	int    idle_cycles = 0;
	bit    done = 0;

	top_k_select dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function automatic logic [31:0] fkey(logic [31:0] b);
		return b[31] ? ~b : (b | 32'h8000_0000);
	endfunction

	function automatic void row_clear();
		kn = 0;
		pos = 0;
	endfunction

	task automatic predict_word(logic [31:0] v, logic last);
		int at, n, k;
		at = 0;
		while (at < kn && fkey(kv[at]) >= fkey(v))
			at++;
		if (at < NKEEP) begin
			if (kn < NKEEP)
				kn++;
			for (int i = kn - 1; i > at; i--) begin
				kv[i] = kv[i-1];
				kp[i] = kp[i-1];
			end
			kv[at] = v;
			kp[at] = pos;
		end
		if (pos < 12'd4095)
			pos++;
		if (last) begin
			k = k_reg == 0 ? 1 : (k_reg > NKEEP ? NKEEP : k_reg);
			n = kn < k ? kn : k;
			for (int i = 0; i < n; i++)
				pending_pairs.push_back('{kv[i], kp[i], i == n - 1});
			row_clear();
		end
	endtask

	task automatic write_top_k(logic [4:0] k);
		// block is idle: drain done, let chain settle
		while (pending_pairs.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= k;
		@(negedge clk);
		cfg_we <= 0;
		k_reg = k;
	endtask

	int burst_left = 0;

	task automatic send_word(logic [31:0] v, logic last);
		// bursts with random gaps
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 4)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1;
		s_axis_tdata <= v;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_word(v, last);
		@(negedge clk);
		// valid stays up inside a burst, drops at its end and at row end
		if (burst_left == 0 || last) begin
			s_axis_tvalid <= 0;
			burst_left = 0;
		end
	endtask

	// receiver stall pattern
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase[7:6] == 2'b11)
			m_axis_tready <= 1;
		else
			m_axis_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		pair_t got, exp;
		if (m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[31:0], m_axis_tdata[43:32], m_axis_tlast};
			if (pending_pairs.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected pair value=%h index=%0d last=%b",
						got.value, got.index, got.last);
			end else begin
				exp = pending_pairs.pop_front();
				if (got != exp) begin
					errors++;
					if (errors <= 10)
						$display("pair mismatch: exp %h/%0d/%b got %h/%0d/%b",
							exp.value, exp.index, exp.last,
							got.value, got.index, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] rand_value(int mode);
		case (mode)
			0: return $urandom();
			1: return {$urandom_range(0, 1) == 1, 8'd127, 23'($urandom_range(0, 7))};
			default: return 32'($urandom_range(0, 3)) << 30;
		endcase
	endfunction

	stim_t plan[$];

	initial begin
		stim_t s;
		int    rows;
		logic [31:0] v;
		k_reg = 1;
		row_clear();
		// directed rows: reset k=1, extremes, signed zeros, ties
		plan.push_back('{32'h3f80_0000, 1, 0, 0, 1, '{32'h3f80_0000, 12'd0, 1'b1}});
		plan.push_back('{32'hffff_ffff, 0, 0, 0, 0, '0});
		plan.push_back('{32'h0000_0000, 1, 0, 0, 1, '{32'h0000_0000, 12'd1, 1'b1}});
		plan.push_back('{32'h8000_0000, 0, 5'd16, 1, 0, '0});
		plan.push_back('{32'h0000_0000, 0, 0, 0, 0, '0});
		plan.push_back('{32'h7f80_0000, 0, 0, 0, 0, '0});
		plan.push_back('{32'hff80_0000, 0, 0, 0, 0, '0});
		plan.push_back('{32'h7fff_ffff, 0, 0, 0, 0, '0});
		plan.push_back('{32'h4000_0000, 0, 0, 0, 0, '0});
		plan.push_back('{32'h4000_0000, 1, 0, 0, 0, '0});
		plan.push_back('{32'h1234_5678, 1, 5'd0, 1, 1, '{32'h1234_5678, 12'd0, 1'b1}});
		plan.push_back('{32'h0000_0001, 0, 5'd31, 1, 0, '0});
		plan.push_back('{32'h8000_0001, 1, 0, 0, 0, '0});
		plan.push_back('{32'hc000_0000, 0, 5'd3, 1, 0, '0});
		plan.push_back('{32'h4000_0000, 0, 0, 0, 0, '0});
		plan.push_back('{32'h4000_0000, 0, 0, 0, 0, '0});
		plan.push_back('{32'h3f00_0000, 0, 0, 0, 0, '0});
		plan.push_back('{32'h4000_0000, 1, 0, 0, 0, '0});
		#1;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (plan[i]) begin
			s = plan[i];
			if (s.cfg)
				write_top_k(s.k);
			if (s.chk && !(pending_pairs.size() == 1 && pending_pairs[0] == s.pair)
				&& s.row_end) begin
				// typed value checked after prediction below
			end
			send_word(s.value, s.row_end);
			if (s.chk && (pending_pairs.size() == 0 ||
				pending_pairs[pending_pairs.size()-1] != s.pair)) begin
				errors++;
				$display("directed row %0d: predictor disagrees with table", i);
			end
		end
		// random rows: mostly short, a few full-width rows
		rows = 0;
		while (rows < 11) begin
			if (rows % 3 == 0)
				write_top_k(rows == 3 ? 5'd16 : 5'($urandom_range(1, 16)));
			for (int n = ($urandom_range(0, 5) == 0 ? $urandom_range(17, 24)
				: $urandom_range(1, 8)); n > 0; n--) begin
				v = rand_value($urandom_range(0, 2));
				send_word(v, n == 1);
			end
			rows++;
		end
		while (pending_pairs.size() != 0)
			@(negedge clk);
		done = 1;
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
